// File: sv/fys_pkg.sv
// Shared constants for the Fisher-Yates shuffle block.
// No dependencies; used by fys_mod, fys_store and fisher_yates_shuffle.
`default_nettype none
package fys_pkg;

	localparam int DATA_W = 32;
	localparam int RND_W  = 32;
	localparam int STEP_W = $clog2(RND_W);

endpackage
`default_nettype wire

// File: sv/fys_mod.sv
// Bit-serial modulo unit: remainder of a 32-bit word by a small divisor.
// One dividend bit per cycle, restoring form. Depends on fys_pkg.
`default_nettype none
module fys_mod #(
	parameter int CW = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [fys_pkg::RND_W-1:0]  dividend,
	input  wire logic [CW-1:0]              divisor,
	output logic                            done,
	output logic [CW-1:0]                   rem
);

	logic                      busy_q;
	logic                      done_q;
	logic [fys_pkg::STEP_W-1:0] step_q;
	logic [fys_pkg::RND_W-1:0] dvd_q;
	logic [CW-1:0]             dsr_q;
	logic [CW-1:0]             rem_q;
	logic [CW:0]               trial;
	logic [CW:0]               diff;
	logic [CW-1:0]             rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[fys_pkg::RND_W-1]};
		diff  = trial - {1'b0, dsr_q};
		if (diff[CW]) begin
			rem_next = trial[CW-1:0];
		end else begin
			rem_next = diff[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + fys_pkg::STEP_W'(1);
				if (step_q == fys_pkg::STEP_W'(fys_pkg::RND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[fys_pkg::RND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// File: sv/fys_store.sv
// Element memory: one write port, two registered read ports.
// Depends on fys_pkg for the element width.
`default_nettype none
module fys_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [fys_pkg::DATA_W-1:0]  wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr_a,
	input  wire logic [AW-1:0]               raddr_b,
	output logic [fys_pkg::DATA_W-1:0]       rdata_a,
	output logic [fys_pkg::DATA_W-1:0]       rdata_b
);

	logic [fys_pkg::DATA_W-1:0] mem [DEPTH];
	logic [fys_pkg::DATA_W-1:0] rd_a_q;
	logic [fys_pkg::DATA_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule
`default_nettype wire

// File: sv/fisher_yates_shuffle.sv
// Top level of the Fisher-Yates shuffle block: control, output register.
// Depends on fys_pkg, fys_mod and fys_store.
//
// channel   dir   tdata                                   tuser      tlast
// s_axis    in    [31:0] element, [63:32] random_word     mode       last
// m_axis    out   [31:0] out_element                      overflow   out_last
//
// A load beat while not shuffling is written to memory, or dropped with an overflow beat if full.
// A random-word beat while shuffling runs the modulo unit, then ST_RD, ST_SWAP_A and ST_SWAP_B.
// Emission reads the memory once per element, then loads the output register.
// Reset clears the count, position and phase; memory content is not cleared.
// A stalled m_axis holds its beat and s_axis drops tready until the beat leaves.
`default_nettype none
module fisher_yates_shuffle #(
	parameter int MAX_ELEMS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] element, [63:32] random_word
	input  wire logic        s_axis_tuser,   // [0] mode
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] out_element
	output logic             m_axis_tuser,   // [0] overflow
	output logic             m_axis_tlast
);

	localparam int IW = $clog2(MAX_ELEMS);
	localparam int CW = $clog2(MAX_ELEMS + 1);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_DIV     = 7'b0000010,
		ST_RD      = 7'b0000100,
		ST_SWAP_A  = 7'b0001000,
		ST_SWAP_B  = 7'b0010000,
		ST_EMIT_RD = 7'b0100000,
		ST_EMIT_WR = 7'b1000000
	} state_t;

	state_t                      state_q;
	logic                        shuf_q;
	logic [CW-1:0]               cnt_q;
	logic [IW-1:0]               pos_q;
	logic [IW-1:0]               j_q;
	logic [IW-1:0]               k_q;
	logic                        out_vld_q;
	logic [fys_pkg::DATA_W-1:0]  out_data_q;
	logic                        out_last_q;
	logic                        out_ovf_q;

	logic                        out_free;
	logic                        in_acc;
	logic                        full;
	logic [CW-1:0]               cnt_new;
	logic                        div_start;
	logic                        div_done;
	logic [CW-1:0]               div_rem;
	logic                        we;
	logic [IW-1:0]               waddr;
	logic [fys_pkg::DATA_W-1:0]  wdata;
	logic                        re;
	logic [IW-1:0]               raddr_a;
	logic [IW-1:0]               raddr_b;
	logic [fys_pkg::DATA_W-1:0]  rdata_a;
	logic [fys_pkg::DATA_W-1:0]  rdata_b;
	logic                        emit_last;

	assign out_free      = !out_vld_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign full          = (cnt_q == CW'(MAX_ELEMS));
	assign cnt_new       = full ? cnt_q : cnt_q + CW'(1);
	assign div_start     = in_acc && shuf_q && s_axis_tuser;
	assign emit_last     = (CW'(k_q) + CW'(1) == cnt_q);

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[IW-1:0];
		wdata = s_axis_tdata[31:0];
		case (state_q)
			ST_IDLE: begin
				we = in_acc && !shuf_q && !s_axis_tuser && !full;
			end
			ST_SWAP_A: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = rdata_b;
			end
			ST_SWAP_B: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = rdata_a;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_comb begin
		re      = (state_q == ST_RD) || (state_q == ST_EMIT_RD);
		raddr_a = (state_q == ST_EMIT_RD) ? k_q : pos_q;
		raddr_b = j_q;
	end

	fys_mod #(
		.CW(CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s_axis_tdata[63:32]),
		.divisor  (CW'(pos_q) + CW'(1)),
		.done     (div_done),
		.rem      (div_rem)
	);

	fys_store #(
		.DEPTH(MAX_ELEMS),
		.AW   (IW)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			shuf_q    <= 1'b0;
			cnt_q     <= '0;
			pos_q     <= '0;
			j_q       <= '0;
			k_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && !shuf_q && !s_axis_tuser) begin
						cnt_q <= cnt_new;
						if (full) begin
							out_vld_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							if (cnt_new == CW'(1)) begin
								k_q     <= '0;
								state_q <= ST_EMIT_RD;
							end else begin
								shuf_q <= 1'b1;
								pos_q  <= IW'(cnt_new - CW'(1));
							end
						end
					end else if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						j_q     <= div_rem[IW-1:0];
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_SWAP_A;
				end
				ST_SWAP_A: begin
					state_q <= ST_SWAP_B;
				end
				ST_SWAP_B: begin
					if (pos_q == IW'(1)) begin
						k_q     <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						pos_q   <= pos_q - IW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						if (emit_last) begin
							cnt_q   <= '0;
							pos_q   <= '0;
							shuf_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + IW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && !shuf_q && !s_axis_tuser && full) begin
			out_data_q <= '0;
			out_last_q <= 1'b0;
			out_ovf_q  <= 1'b1;
		end else if (state_q == ST_EMIT_WR && out_free) begin
			out_data_q <= rdata_a;
			out_last_q <= emit_last;
			out_ovf_q  <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for fisher_yates_shuffle: streams list loads and random-word beats into s_axis,
// tracks the shuffle in a behavioral predictor and checks every m_axis beat in order.
// Needs the fisher_yates_shuffle, fys_mod and fys_store RTL and fys_pkg.
module tb;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_RANDOM  = 1'b1;
	localparam int   CAPACITY     = 64;
	localparam int   IDLE_LIMIT   = 4000;
	localparam int   LONG_HOLD    = 300;
	localparam int   HOLD_AFTER   = 40;
	localparam int   ITEM_TARGET  = 150;

	typedef enum logic {SHUF_LOADING, SHUF_SWAPPING} shuf_phase_t;

	typedef struct {
		logic        mode;
		logic [31:0] element;
		logic [31:0] rword;
		logic        last;
		bit          drain;
	} load_beat_t;

	typedef struct {
		logic [31:0] element;
		logic        last;
		logic        overflow;
	} list_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = 64'd0;   // [31:0] element, [63:32] random_word
	logic        s_axis_tuser = 1'b0;    // [0] mode
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // [31:0] out_element
	logic        m_axis_tuser;           // [0] overflow
	logic        m_axis_tlast;

	fisher_yates_shuffle dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	load_beat_t  pending_q[$];
	list_beat_t  shuffled_q[$];

	logic [31:0] list_mem [CAPACITY];
	int unsigned list_len = 0;
	int unsigned swap_pos = 0;
	shuf_phase_t shuf_phase = SHUF_LOADING;

	int errors = 0;
	int results_seen = 0;
	int beats_in = 0;
	int lists_done = 0;
	int overflows = 0;
	int swap_steps = 0;
	int real_items = 0;
	int idle_cycles = 0;

	logic in_taken = 1'b0;
	int   burst_left = 0;
	int   gap_left = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	logic [6:0] stall_phase = 7'd0;

	task automatic queue_result(input logic [31:0] e, input logic l, input logic o);
		list_beat_t b;
		b.element = e;
		b.last = l;
		b.overflow = o;
		shuffled_q.push_back(b);
	endtask

	task automatic release_list();
		for (int k = 0; k < list_len; k++)
			queue_result(list_mem[k], (k + 1 == list_len), 1'b0);
		lists_done++;
		list_len = 0;
		swap_pos = 0;
		shuf_phase = SHUF_LOADING;
	endtask

	task automatic shuffle_model(input load_beat_t b);
		int unsigned j;
		logic [31:0] t;
		if (shuf_phase == SHUF_LOADING) begin
			if (b.mode == MODE_LOAD) begin
				if (list_len < CAPACITY) begin
					list_mem[list_len] = b.element;
					list_len++;
				end else begin
					queue_result(32'd0, 1'b0, 1'b1);
					overflows++;
				end
				if (b.last) begin
					if (list_len == 1) begin
						release_list();
					end else if (list_len >= 2) begin
						swap_pos = list_len - 1;
						shuf_phase = SHUF_SWAPPING;
					end
				end
			end
		end else if (b.mode == MODE_RANDOM) begin
			if (swap_pos == 0 || swap_pos >= list_len) begin
				release_list();
			end else begin
				swap_steps++;
				j = b.rword % (swap_pos + 1);
				if (j != swap_pos) begin
					t = list_mem[swap_pos];
					list_mem[swap_pos] = list_mem[j];
					list_mem[j] = t;
				end
				if (swap_pos == 1)
					release_list();
				else
					swap_pos = swap_pos - 1;
			end
		end
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_beat(input logic mode, input logic [31:0] e, input logic [31:0] r,
			input logic l, input bit drain, input bit noise);
		load_beat_t b;
		b.mode = mode;
		b.element = e;
		b.rword = r;
		b.last = l;
		b.drain = drain;
		pending_q.push_back(b);
		if (!noise)
			real_items++;
	endtask

	// n loads, last marked, then one random word per swap step; if rough, stray beats, maybe one step fewer
	task automatic add_list(input int n, input bit drain, input bit rough);
		int steps;
		for (int k = 0; k < n; k++) begin
			if (rough && k > 0 && $urandom_range(0, 7) == 0)
				add_beat(MODE_RANDOM, $urandom, pick_word(), 1'($urandom_range(0, 1)),
					1'b0, 1'b1);
			add_beat(MODE_LOAD, pick_word(), $urandom, (k == n - 1), drain && k == 0, 1'b0);
		end
		steps = (n > CAPACITY ? CAPACITY : n) - 1;
		if (rough && steps > 0 && $urandom_range(0, 9) == 0)
			steps--;
		for (int k = 0; k < steps; k++) begin
			if (rough && $urandom_range(0, 7) == 0)
				add_beat(MODE_LOAD, $urandom, $urandom, 1'($urandom_range(0, 1)),
					1'b0, 1'b1);
			add_beat(MODE_RANDOM, $urandom, pick_word(), 1'($urandom_range(0, 1)),
				1'b0, 1'b0);
		end
	endtask

	// driver: advance to the next beat once the current one is taken
	always @(negedge clk) begin
		load_beat_t nxt;
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (gap_left > 0 && hold_left == 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_q.size() > 0
						&& !(pending_q[0].drain && shuffled_q.size() != 0)) begin
					nxt = pending_q.pop_front();
					s_axis_tdata <= {nxt.rword, nxt.element};
					s_axis_tuser <= nxt.mode;
					s_axis_tlast <= nxt.last;
					s_axis_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: a rotating pattern of free, light and heavy stalls, with one long hold after HOLD_AFTER results
	always @(negedge clk) begin
		if (arst_n) begin
			stall_phase <= stall_phase + 7'd1;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && m_axis_tvalid && results_seen >= HOLD_AFTER) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
				m_axis_tready <= 1'b0;
			end else begin
				case (stall_phase[6:5])
					2'd2: m_axis_tready <= ($urandom_range(0, 2) != 0);
					2'd3: m_axis_tready <= ($urandom_range(0, 5) == 0);
					default: m_axis_tready <= 1'b1;
				endcase
			end
		end
	end

	// monitor: check result beats, feed accepted input beats to the predictor
	always @(posedge clk) begin
		list_beat_t want;
		load_beat_t got_in;
		if (arst_n) begin
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (shuffled_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat: element %h last %b overflow %b",
						$realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser);
				end else begin
					want = shuffled_q.pop_front();
					if (m_axis_tdata !== want.element || m_axis_tlast !== want.last
							|| m_axis_tuser !== want.overflow) begin
						errors++;
						$display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b",
							$realtime, want.element, want.last, want.overflow,
							m_axis_tdata, m_axis_tlast, m_axis_tuser);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				got_in.mode = s_axis_tuser;
				got_in.element = s_axis_tdata[31:0];
				got_in.rword = s_axis_tdata[63:32];
				got_in.last = s_axis_tlast;
				got_in.drain = 1'b0;
				shuffle_model(got_in);
				beats_in++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
					$realtime, idle_cycles, shuffled_q.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int n;
		int list_idx;

		// single-element lists at the signed extremes, with a stray random word between
		add_beat(MODE_LOAD, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
		add_beat(MODE_RANDOM, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b0, 1'b0);
		add_beat(MODE_LOAD, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b0, 1'b0);
		// two elements, load while shuffling, no swap
		add_beat(MODE_LOAD, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
		add_beat(MODE_LOAD, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, 1'b0);
		add_beat(MODE_LOAD, 32'h1234_5678, 32'h8765_4321, 1'b1, 1'b0, 1'b0);
		add_beat(MODE_RANDOM, 32'h0000_0000, 32'hffff_ffff, 1'b0, 1'b0, 1'b0);
		// two elements, swapped
		add_beat(MODE_LOAD, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
		add_beat(MODE_LOAD, 32'hffff_fffe, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
		add_beat(MODE_RANDOM, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
		// three elements after a full drain
		add_beat(MODE_LOAD, 32'h8000_0000, 32'h5555_5555, 1'b0, 1'b1, 1'b0);
		add_beat(MODE_LOAD, 32'h7fff_ffff, 32'haaaa_aaaa, 1'b0, 1'b0, 1'b0);
		add_beat(MODE_LOAD, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
		add_beat(MODE_RANDOM, 32'haaaa_aaaa, 32'h0000_0004, 1'b0, 1'b0, 1'b0);
		add_beat(MODE_RANDOM, 32'h5555_5555, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
		// full store, one drop without the last mark, one drop that closes the list
		add_list(CAPACITY + 2, 1'b1, 1'b0);

		list_idx = 0;
		while (real_items < ITEM_TARGET) begin
			r = $urandom_range(0, 24);
			if (r <= 4)
				n = 1;
			else
				n = $urandom_range(2, 8);
			add_list(n, (list_idx > 0 && $urandom_range(0, 5) == 0), 1'b1);
			list_idx++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (shuffled_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Input beats %0d, swap steps %0d, lists emitted %0d, overflow drops %0d.",
			beats_in, swap_steps, lists_done, overflows);
		$display("Result beats checked %0d, errors %0d.", results_seen, errors);
		if (errors == 0 && shuffled_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
